FILE: hdl/ialu_pkg.sv
// Package for the integer ALU: operation codes, field widths and the
// transfer structs of both channels. No dependencies.
`timescale 1ns / 1ps

package ialu_pkg;

  localparam int FIELD_W       = 32;
  localparam int DEFAULT_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  typedef struct packed {
    logic [2:0]                 op;
    logic signed [FIELD_W-1:0]  operand_a;
    logic signed [FIELD_W-1:0]  operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  result;
    logic                       error;
  } alu_out_t;

endpackage

FILE: hdl/integer_alu_add_sub_mul_div_pow.sv
// Integer ALU top level: add, subtract, multiply, divide and power on one
// shared add/subtract unit under a small sequencer. Depends on ialu_pkg.
`timescale 1ns / 1ps
//
//  channel  | signals                    | carries
//  ---------+----------------------------+----------------------------
//  in       | in_valid, in_stall, in_data| op, operand_a, operand_b
//  out      | out_valid, out_stall, out_data | result, error
//
//  Multiply: one multiplier bit per cycle through the shared adder. Divide: one
//  quotient bit per cycle. Power: square and multiply, each product a serial
//  multiply on the same adder.
//  Synchronous reset clears the sequencer and the output valid.
//  in_stall stays high from a transfer until the result moves to the output
//  register; a stalled output does not block the next input transfer.

module integer_alu_add_sub_mul_div_pow
  import ialu_pkg::*;
#(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  alu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output alu_out_t out_data
);

  localparam int CW = $clog2(WIDTH + 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DISP = 9'b000000010,
    ST_NEGA = 9'b000000100,
    ST_NEGB = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_FIX  = 9'b000100000,
    ST_MUL  = 9'b001000000,
    ST_POW  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t           state;
  logic [2:0]       opr;
  logic [WIDTH-1:0] mc, mp, acc, sq, pw, e, res;
  logic             err, neg, ph;
  logic [CW-1:0]    cnt;

  logic [WIDTH-1:0] u_a, u_b, u_sum;
  logic             u_sub, u_co;
  logic [WIDTH-1:0] rem_shift;
  logic signed [63:0] a64, b64, r64;
  logic             out_load;

  function automatic logic [WIDTH-1:0] ext(input logic signed [63:0] v);
    return v[WIDTH-1:0];
  endfunction

  assign a64       = 64'($signed(in_data.operand_a));
  assign b64       = 64'($signed(in_data.operand_b));
  assign r64       = 64'($signed(res));
  assign rem_shift = {acc[WIDTH-2:0], mc[WIDTH-1]};
  assign in_stall  = (state != ST_IDLE);
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_sub = 1'b0;
    case (state)
      ST_DISP: begin
        u_a   = mc;
        u_b   = mp;
        u_sub = (opr == OP_SUB);
      end
      ST_NEGA: begin
        u_b   = mc;
        u_sub = 1'b1;
      end
      ST_NEGB: begin
        u_b   = mp;
        u_sub = 1'b1;
      end
      ST_DIV: begin
        u_a   = rem_shift;
        u_b   = mp;
        u_sub = 1'b1;
      end
      ST_FIX: begin
        u_b   = mc;
        u_sub = 1'b1;
      end
      ST_MUL: begin
        u_a = acc;
        u_b = mc;
      end
      default: begin
        u_sub = 1'b0;
      end
    endcase
    {u_co, u_sum} = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (WIDTH + 1)'(u_sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            opr   <= in_data.op;
            mc    <= ext(a64);
            mp    <= ext(b64);
            state <= ST_DISP;
          end
        end
        ST_DISP: begin
          err <= ((opr == OP_DIV) && (mp == '0)) ||
                 ((opr == OP_POW) && (mc == '0) && (mp == '0));
          case (opr)
            OP_ADD, OP_SUB: begin
              res   <= u_sum;
              state <= ST_OUT;
            end
            OP_MUL: begin
              acc   <= '0;
              state <= ST_MUL;
            end
            OP_DIV: begin
              if (mp == '0) begin
                res   <= '0;
                state <= ST_OUT;
              end else begin
                neg   <= mc[WIDTH-1] ^ mp[WIDTH-1];
                state <= ST_NEGA;
              end
            end
            OP_POW: begin
              if (mc == '0) begin
                res   <= '0;
                state <= ST_OUT;
              end else if (mp == '0) begin
                res   <= WIDTH'(1);
                state <= ST_OUT;
              end else if (!mp[WIDTH-1]) begin
                sq    <= mc;
                e     <= mp;
                pw    <= WIDTH'(1);
                ph    <= 1'b0;
                state <= ST_POW;
              end else begin
                res   <= '0;
                state <= ST_OUT;
              end
            end
            default: begin
              res   <= '0;
              state <= ST_OUT;
            end
          endcase
        end
        ST_NEGA: begin
          if (mc[WIDTH-1]) begin
            mc <= u_sum;
          end
          state <= ST_NEGB;
        end
        ST_NEGB: begin
          if (mp[WIDTH-1]) begin
            mp <= u_sum;
          end
          acc   <= '0;
          cnt   <= CW'(WIDTH);
          state <= ST_DIV;
        end
        ST_DIV: begin
          acc <= u_co ? u_sum : rem_shift;
          mc  <= {mc[WIDTH-2:0], u_co};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          res   <= neg ? u_sum : mc;
          state <= ST_OUT;
        end
        ST_MUL: begin
          if (mp == '0) begin
            if (opr == OP_MUL) begin
              res   <= acc;
              state <= ST_OUT;
            end else begin
              if (ph) begin
                sq <= acc;
                e  <= e >> 1;
                ph <= 1'b0;
              end else begin
                pw <= acc;
                ph <= 1'b1;
              end
              state <= ST_POW;
            end
          end else begin
            if (mp[0]) begin
              acc <= u_sum;
            end
            mc <= mc << 1;
            mp <= mp >> 1;
          end
        end
        ST_POW: begin
          acc <= '0;
          if (!ph && e[0]) begin
            mc    <= sq;
            mp    <= pw;
            state <= ST_MUL;
          end else if (|e[WIDTH-1:1]) begin
            mc    <= sq;
            mp    <= sq;
            ph    <= 1'b1;
            state <= ST_MUL;
          end else begin
            res   <= pw;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.result <= r64[FIELD_W-1:0];
            out_data.error  <= err;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.result == '0)
    else $error("error result with nonzero value");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("output loaded outside the output state");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("ready again right after an input transfer");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> cnt != '0)
    else $error("divide step with an empty bit count");
`endif

endmodule
